// ===== rtl/pss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the pen stroke smoother.
package pss_pkg;

  localparam int CoordW = 24;
  localparam int WidthW = 16;
  localparam int SegW   = 16;
  localparam int CmdW   = 2;
  localparam int PressW = 11;
  localparam int ThickW = 8;
  localparam int Taps   = 5;
  localparam int SlotW  = 3;
  localparam int CountW = 3;
  localparam int SumW   = 28;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [WidthW-1:0]        width_t;

  // Command codes.
  localparam logic [CmdW-1:0] CmdPress   = 2'd0;
  localparam logic [CmdW-1:0] CmdMove    = 2'd1;
  localparam logic [CmdW-1:0] CmdRelease = 2'd2;

  // Result kinds.
  localparam logic KindRaw       = 1'b0;
  localparam logic KindCorrected = 1'b1;

  // Window slots, slot four holds the newest point.
  localparam logic [SlotW-1:0] SlotOldest = 3'd0;
  localparam logic [SlotW-1:0] SlotSecond = 3'd1;
  localparam logic [SlotW-1:0] SlotThird  = 3'd2;
  localparam logic [SlotW-1:0] SlotPrev   = 3'd3;
  localparam logic [SlotW-1:0] SlotNewest = 3'd4;

  localparam logic [CountW-1:0] CountMax = 3'd6;

  // Smoothing kernel 1,3,7,3,1 over 15, rounded to nearest.
  localparam logic signed [SumW-1:0] TapWeight [Taps] = '{28'sd1, 28'sd3, 28'sd7, 28'sd3, 28'sd1};
  localparam int RoundBias = 7;
  // floor(n/15) == (n * DivMul) >> DivShift for every n below 2^28.
  localparam logic [SumW-1:0] DivMul = 28'd143165577;
  localparam int DivShift = 31;

  // Thickness in Q8.8: pressure * max * 3 / 16 rounded, plus 256 * floor(max / 4).
  localparam int ThickMul   = 3;
  localparam int ThickRound = 8;
  localparam int ThickShift = 4;
  localparam logic [WidthW-1:0] WidthMax = 16'd65280;
  localparam logic [ThickW-1:0] ThickReset = 8'd4;

  // Smallest Manhattan step that adds a point, one scene unit in Q16.8.
  localparam int MinStep = 256;

  typedef struct packed {
    logic            kind;
    logic [SegW-1:0] segment_index;
    coord_t          from_x;
    coord_t          from_y;
    coord_t          to_x;
    coord_t          to_y;
    width_t          width;
    logic            last;
  } result_t;

endpackage

// ===== rtl/pss_if.sv =====
`timescale 1ns / 1ps
// Stream interfaces for pen events in and segments out.
interface pss_in_if;
  import pss_pkg::*;

  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     cmd;
  coord_t              pos_x;
  coord_t              pos_y;
  logic [PressW-1:0]   pressure;

  modport source (output valid, cmd, pos_x, pos_y, pressure, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, pressure, output ready);
endinterface

interface pss_out_if;
  import pss_pkg::*;

  logic            valid;
  logic            ready;
  logic            kind;
  logic [SegW-1:0] segment_index;
  coord_t          from_x;
  coord_t          from_y;
  coord_t          to_x;
  coord_t          to_y;
  width_t          width;
  logic            last;

  modport source (output valid, kind, segment_index, from_x, from_y, to_x, to_y, width, last,
                  input ready);
  modport sink   (input valid, kind, segment_index, from_x, from_y, to_x, to_y, width, last,
                  output ready);
endinterface

// ===== rtl/pss_wmean.sv =====
`timescale 1ns / 1ps
// Five-tap weighted mean over a window with taps clamped to the stroke ends.
module pss_wmean (
  input  pss_pkg::coord_t               win_i [pss_pkg::Taps],
  input  logic [pss_pkg::SlotW-1:0]     center_i,
  input  logic [pss_pkg::SlotW-1:0]     low_i,
  output pss_pkg::coord_t               mean_o
);
  import pss_pkg::*;

  coord_t                 ext [Taps+2];
  coord_t                 tap [Taps];
  logic signed [SumW-1:0] sum;
  logic [SumW-1:0]        mag;
  logic [SumW-1:0]        biased;
  logic [2*SumW-1:0]      prod;
  logic [CoordW-1:0]      quo;

  // Slots below the oldest valid one repeat it; positions past the newest repeat the newest.
  always_comb begin
    ext[Taps-1] = win_i[Taps-1];
    ext[Taps]   = win_i[Taps-1];
    ext[Taps+1] = win_i[Taps-1];
    for (int s = Taps - 2; s >= 0; s--) begin
      ext[s] = (SlotW'(s) < low_i) ? ext[s+1] : win_i[s];
    end
  end

  always_comb begin
    for (int i = 0; i < Taps; i++) begin
      case (center_i)
        SlotThird: tap[i] = ext[i];
        SlotPrev:  tap[i] = ext[i+1];
        default:   tap[i] = ext[i+2];
      endcase
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < Taps; i++) begin
      sum = sum + SumW'(tap[i]) * TapWeight[i];
    end
  end

  // Round half away from zero on the magnitude, then restore the sign.
  assign mag    = sum[SumW-1] ? -sum : sum;
  assign biased = mag + SumW'(RoundBias);
  assign prod   = (2*SumW)'(biased) * (2*SumW)'(DivMul);
  assign quo    = prod[DivShift +: CoordW];
  assign mean_o = sum[SumW-1] ? coord_t'(-quo) : coord_t'(quo);

endmodule

// ===== rtl/pss_out_reg.sv =====
`timescale 1ns / 1ps
// Output register that holds one segment until the sink takes it.
module pss_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pss_pkg::result_t  res_i,
  output logic              free_o,
  pss_out_if.source         out_o
);
  import pss_pkg::*;

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = push_i ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.kind          = res_q.kind;
  assign out_o.segment_index = res_q.segment_index;
  assign out_o.from_x        = res_q.from_x;
  assign out_o.from_y        = res_q.from_y;
  assign out_o.to_x          = res_q.to_x;
  assign out_o.to_y          = res_q.to_y;
  assign out_o.width         = res_q.width;
  assign out_o.last          = res_q.last;

endmodule

// ===== rtl/pen_stroke_smoother.sv =====
`timescale 1ns / 1ps
// Top level of the pen stroke smoother: event register, stroke window and control.
//
//  Channel  Direction  Handshake            Carries
//  in_i     in         valid / ready        cmd, pos_x, pos_y, pressure
//  out_o    out        valid / ready        kind, segment_index, from/to x/y, width, last
//  cfg      in         cfg_we_i             max_thickness on cfg_wdata_i
//
// One result at most leaves per cycle. Press, ignored events, a short release and the move
// that adds the second point take one step; other moves and a release of a long stroke take two
// steps, since one set of mean units handles each step. Every step needs a free output register.
// The event register frees as the last step completes, so the next event is taken in that cycle.
// A stalled output holds the event in place. Reset closes any stroke, max thickness is 4.
module pen_stroke_smoother #(
  parameter int INDEX_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pss_pkg::ThickW-1:0]  cfg_wdata_i,
  pss_in_if.sink                      in_i,
  pss_out_if.source                   out_o
);
  import pss_pkg::*;

  typedef enum logic [1:0] {
    PhFirst  = 2'b01,
    PhSecond = 2'b10
  } phase_e;

  localparam int SegOutW = (INDEX_WIDTH < SegW) ? INDEX_WIDTH : SegW;

  function automatic logic [SegW-1:0] seg_out(input logic [INDEX_WIDTH-1:0] v);
    seg_out = SegW'(v[SegOutW-1:0]);
  endfunction

  // Event register.
  logic              item_valid_q, item_valid_d;
  logic [CmdW-1:0]   cmd_q;
  coord_t            pos_x_q, pos_y_q;
  logic [PressW-1:0] pressure_q;
  logic              in_acc;

  // Stroke state.
  coord_t             win_x_q [Taps];
  coord_t             win_x_d [Taps];
  coord_t             win_y_q [Taps];
  coord_t             win_y_d [Taps];
  width_t             win_w_q [Taps];
  width_t             win_w_d [Taps];
  coord_t             win_wc  [Taps];
  logic [CountW-1:0]  count_q, count_d;
  logic [INDEX_WIDTH-1:0] seg_q, seg_d;
  logic               active_q, active_d;
  phase_e             phase_q, phase_d;
  logic [ThickW-1:0]  max_thick_q;

  logic step, item_done, push, out_free;
  result_t res;

  logic [SlotW-1:0] m_center, low_p, low_w;
  coord_t mean_x, mean_y, mean_w;
  width_t mean_w16;

  logic [20:0]            thick_prod;
  logic [16:0]            thick_sum;
  width_t                 thick;
  logic signed [CoordW:0] dx, dy;
  logic [CoordW:0]        adx, ady;
  logic [CoordW+1:0]      manhattan;
  logic                   far;
  logic [INDEX_WIDTH-1:0] seg_m1, seg_m2, seg_m3;

  assign step      = item_valid_q && out_free;
  assign in_i.ready = !item_valid_q || item_done;
  assign in_acc    = in_i.valid && in_i.ready;
  assign item_valid_d = in_acc ? 1'b1 : (item_done ? 1'b0 : item_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      max_thick_q  <= ThickReset;
      count_q      <= '0;
      seg_q        <= '0;
      active_q     <= 1'b0;
      phase_q      <= PhFirst;
    end else begin
      item_valid_q <= item_valid_d;
      if (cfg_we_i) begin
        max_thick_q <= cfg_wdata_i;
      end
      count_q  <= count_d;
      seg_q    <= seg_d;
      active_q <= active_d;
      phase_q  <= phase_d;
    end
  end

  // The window is loaded by a press before any read, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q      <= in_i.cmd;
      pos_x_q    <= in_i.pos_x;
      pos_y_q    <= in_i.pos_y;
      pressure_q <= in_i.pressure;
    end
    if (step) begin
      win_x_q <= win_x_d;
      win_y_q <= win_y_d;
      win_w_q <= win_w_d;
    end
  end

  // Thickness from pressure.
  assign thick_prod = 21'(pressure_q) * 21'(max_thick_q) * 21'(ThickMul);
  assign thick_sum  = 17'((thick_prod + 21'(ThickRound)) >> ThickShift)
                    + 17'({max_thick_q[ThickW-1:2], 8'd0});
  assign thick      = (thick_sum > 17'(WidthMax)) ? WidthMax : thick_sum[WidthW-1:0];

  // Manhattan distance to the newest point.
  assign dx   = (CoordW+1)'(pos_x_q) - (CoordW+1)'(win_x_q[SlotNewest]);
  assign dy   = (CoordW+1)'(pos_y_q) - (CoordW+1)'(win_y_q[SlotNewest]);
  assign adx  = dx[CoordW] ? -dx : dx;
  assign ady  = dy[CoordW] ? -dy : dy;
  assign manhattan = (CoordW+2)'(adx) + (CoordW+2)'(ady);
  assign far  = manhattan >= (CoordW+2)'(MinStep);

  assign seg_m1 = seg_q - INDEX_WIDTH'(1);
  assign seg_m2 = seg_q - INDEX_WIDTH'(2);
  assign seg_m3 = seg_q - INDEX_WIDTH'(3);

  // Mean units: a move smooths the point two behind, a release the last two in turn.
  always_comb begin
    if (cmd_q == CmdMove) begin
      m_center = SlotThird;
    end else if (phase_q == PhFirst) begin
      m_center = SlotPrev;
    end else begin
      m_center = SlotNewest;
    end
    if (count_q >= 3'd5) begin
      low_p = SlotOldest;
    end else if (count_q <= 3'd1) begin
      low_p = SlotNewest;
    end else begin
      low_p = 3'd5 - count_q;
    end
    if (count_q >= CountMax) begin
      low_w = SlotOldest;
    end else if (count_q <= 3'd2) begin
      low_w = SlotNewest;
    end else begin
      low_w = 3'd6 - count_q;
    end
    for (int i = 0; i < Taps; i++) begin
      win_wc[i] = coord_t'({{(CoordW-WidthW){1'b0}}, win_w_q[i]});
    end
  end

  pss_wmean u_mean_x (.win_i(win_x_q), .center_i(m_center), .low_i(low_p), .mean_o(mean_x));
  pss_wmean u_mean_y (.win_i(win_y_q), .center_i(m_center), .low_i(low_p), .mean_o(mean_y));
  pss_wmean u_mean_w (.win_i(win_wc),  .center_i(m_center), .low_i(low_w), .mean_o(mean_w));

  assign mean_w16 = mean_w[WidthW-1:0];

  always_comb begin
    win_x_d   = win_x_q;
    win_y_d   = win_y_q;
    win_w_d   = win_w_q;
    count_d   = count_q;
    seg_d     = seg_q;
    active_d  = active_q;
    phase_d   = phase_q;
    push      = 1'b0;
    res       = '0;
    item_done = 1'b0;
    if (step) begin
      item_done = 1'b1;
      phase_d   = PhFirst;
      unique case (cmd_q)
        CmdPress: begin
          for (int i = 0; i < Taps; i++) begin
            win_x_d[i] = '0;
            win_y_d[i] = '0;
            win_w_d[i] = '0;
          end
          win_x_d[SlotNewest] = pos_x_q;
          win_y_d[SlotNewest] = pos_y_q;
          count_d  = 3'd1;
          seg_d    = '0;
          active_d = 1'b1;
        end
        CmdMove: begin
          if (phase_q == PhFirst) begin
            if (active_q && far) begin
              for (int i = 0; i < Taps - 1; i++) begin
                win_x_d[i] = win_x_q[i+1];
                win_y_d[i] = win_y_q[i+1];
                win_w_d[i] = win_w_q[i+1];
              end
              win_x_d[SlotNewest] = pos_x_q;
              win_y_d[SlotNewest] = pos_y_q;
              win_w_d[SlotNewest] = thick;
              if (count_q < CountMax) begin
                count_d = count_q + 3'd1;
              end
              seg_d = seg_q + INDEX_WIDTH'(1);
              push              = 1'b1;
              res.kind          = KindRaw;
              res.segment_index = seg_out(seg_q);
              res.from_x        = win_x_q[SlotNewest];
              res.from_y        = win_y_q[SlotNewest];
              res.to_x          = pos_x_q;
              res.to_y          = pos_y_q;
              res.width         = thick;
              res.last          = count_q < 3'd3;
              // From the third point on, the point two behind is smoothed in a second step.
              if (count_q >= 3'd2) begin
                item_done = 1'b0;
                phase_d   = PhSecond;
              end
            end
          end else begin
            win_x_d[SlotThird] = mean_x;
            win_y_d[SlotThird] = mean_y;
            // On the third point the first point is smoothed without a result.
            if (count_q >= 3'd4) begin
              win_w_d[SlotThird] = mean_w16;
              push              = 1'b1;
              res.kind          = KindCorrected;
              res.segment_index = seg_out(seg_m3);
              res.from_x        = win_x_q[SlotSecond];
              res.from_y        = win_y_q[SlotSecond];
              res.to_x          = mean_x;
              res.to_y          = mean_y;
              res.width         = mean_w16;
              res.last          = 1'b1;
            end
          end
        end
        CmdRelease: begin
          if (phase_q == PhFirst) begin
            if (active_q) begin
              active_d = 1'b0;
              if (count_q > 3'd3) begin
                win_x_d[SlotPrev] = mean_x;
                win_y_d[SlotPrev] = mean_y;
                win_w_d[SlotPrev] = mean_w16;
                push              = 1'b1;
                res.kind          = KindCorrected;
                res.segment_index = seg_out(seg_m2);
                res.from_x        = win_x_q[SlotThird];
                res.from_y        = win_y_q[SlotThird];
                res.to_x          = mean_x;
                res.to_y          = mean_y;
                res.width         = mean_w16;
                res.last          = 1'b0;
                item_done         = 1'b0;
                phase_d           = PhSecond;
              end
            end
          end else begin
            win_x_d[SlotNewest] = mean_x;
            win_y_d[SlotNewest] = mean_y;
            win_w_d[SlotNewest] = mean_w16;
            push              = 1'b1;
            res.kind          = KindCorrected;
            res.segment_index = seg_out(seg_m1);
            res.from_x        = win_x_q[SlotPrev];
            res.from_y        = win_y_q[SlotPrev];
            res.to_x          = mean_x;
            res.to_y          = mean_y;
            res.width         = mean_w16;
            res.last          = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  pss_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

`ifndef SYNTH
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_valid_q |-> in_i.ready)
    else $error("event register empty but input not ready");

  a_second_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhSecond |-> item_valid_q)
    else $error("second step pending without an event");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountMax)
    else $error("point count beyond saturation");

  a_second_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && phase_q == PhSecond |=> phase_q == PhFirst)
    else $error("second step did not complete the event");

  a_release_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && cmd_q == CmdRelease && phase_q == PhFirst |=> !active_q)
    else $error("release left the stroke open");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the pen stroke smoother with a built-in stroke predictor.
module tb;
  import pss_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam coord_t CoordMin = 24'sh800000;
  localparam coord_t CoordMax = 24'sh7FFFFF;
  localparam int Kernel [Taps] = '{1, 3, 7, 3, 1};
  localparam int KernelSum = 15;
  localparam int MaxGap = 17;
  localparam int DrainCycles = 8;
  localparam int DirCount = 25;
  localparam int PhaseCount = 6;
  localparam int PhaseItems = 85;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    coord_t            pos_x;
    coord_t            pos_y;
    logic [PressW-1:0] pressure;
  } pen_event_t;

  typedef struct packed {
    pen_event_t ev;
    logic       fixed;
    result_t    res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [ThickW-1:0] cfg_wdata_i;

  pss_in_if  in_if ();
  pss_out_if out_if ();

  pen_stroke_smoother dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predictor state.
  longint       win_x [Taps];
  longint       win_y [Taps];
  longint       win_w [Taps];
  int           point_total;
  logic [15:0]  segment_total;
  logic         stroke_open;
  logic [ThickW-1:0] thickness_max;

  result_t expected_segments [$];
  int      fail_count;
  int      events_taken;
  bit      in_calm;
  bit      out_calm;
  int      out_transfers;
  result_t got_segment;
  result_t want_segment;

  // Directed rows: idle commands, drops, early points, a long stroke, a short stroke,
  // coordinate and pressure extremes, and a press that abandons an open stroke.
  stim_row_t directed_rows [DirCount] = '{
    '{'{CmdMove,    24'sd256,   24'sd0,    11'd512},  1'b0, '0},
    '{'{CmdRelease, 24'sd0,     24'sd0,    11'd0},    1'b0, '0},
    '{'{CmdUnused,  24'sd0,     24'sd0,    11'd0},    1'b0, '0},
    '{'{CmdPress,   24'sd0,     24'sd0,    11'd0},    1'b0, '0},
    '{'{CmdMove,    24'sd256,   24'sd0,    11'd1024}, 1'b1,
      '{KindRaw, 16'd0, 24'sd0, 24'sd0, 24'sd256, 24'sd0, 16'd1024, 1'b1}},
    '{'{CmdMove,    24'sd300,   24'sd0,    11'd1024}, 1'b0, '0},
    '{'{CmdMove,    24'sd256,   24'sd255,  11'd1024}, 1'b0, '0},
    '{'{CmdMove,    24'sd512,   24'sd0,    11'd0},    1'b1,
      '{KindRaw, 16'd1, 24'sd256, 24'sd0, 24'sd512, 24'sd0, 16'd256, 1'b1}},
    '{'{CmdMove,    24'sd1024,  24'sd512,  11'd2047}, 1'b0, '0},
    '{'{CmdUnused,  24'sd7,     24'sd7,    11'd7},    1'b0, '0},
    '{'{CmdMove,    -24'sd1000, 24'sd2000, 11'd700},  1'b0, '0},
    '{'{CmdMove,    -24'sd3000, -24'sd2500, 11'd1},   1'b0, '0},
    '{'{CmdMove,    24'sd4000,  24'sd100,  11'd1023}, 1'b0, '0},
    '{'{CmdMove,    24'sd4300,  -24'sd400, 11'd64},   1'b0, '0},
    '{'{CmdRelease, 24'sd0,     24'sd0,    11'd0},    1'b0, '0},
    '{'{CmdPress,   24'sd5,     24'sd5,    11'd0},    1'b0, '0},
    '{'{CmdMove,    24'sd261,   24'sd5,    11'd300},  1'b0, '0},
    '{'{CmdMove,    24'sd261,   24'sd261,  11'd300},  1'b0, '0},
    '{'{CmdRelease, 24'sd0,     24'sd0,    11'd0},    1'b0, '0},
    '{'{CmdPress,   CoordMin,   CoordMin,  11'd0},    1'b0, '0},
    '{'{CmdMove,    CoordMax,   CoordMax,  11'd2047}, 1'b1,
      '{KindRaw, 16'd0, CoordMin, CoordMin, CoordMax, CoordMax, 16'd1791, 1'b1}},
    '{'{CmdMove,    CoordMin,   CoordMax,  11'd1024}, 1'b0, '0},
    '{'{CmdMove,    CoordMax,   CoordMin,  11'd0},    1'b0, '0},
    '{'{CmdPress,   24'sd0,     24'sd0,    11'd0},    1'b0, '0},
    '{'{CmdMove,    24'sd0,     -24'sd256, 11'd512},  1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[pen_stroke_smoother] ERROR");
    $finish;
  end

  function automatic longint weighted_mean(input longint win [Taps], input int center,
                                           input int low);
    longint sum;
    int r;
    sum = 0;
    for (int i = 0; i < Taps; i++) begin
      r = center + i - 2;
      if (r < low) r = low;
      if (r < -(Taps - 1)) r = -(Taps - 1);
      if (r > 0) r = 0;
      sum += win[Taps - 1 + r] * Kernel[i];
    end
    if (sum >= 0) return (sum + KernelSum / 2) / KernelSum;
    return -((-sum + KernelSum / 2) / KernelSum);
  endfunction

  function automatic int point_floor();
    return (point_total >= 6) ? -(Taps - 1) : -(point_total - 1);
  endfunction

  function automatic int width_floor();
    return (point_total >= 6) ? -(Taps - 1) : -(point_total - 2);
  endfunction

  // Smooths the point at relative slot pc and the thickness at wc in place and builds
  // the corrected segment that ends at that point.
  function automatic result_t smooth_at(input int pc, input int wc, input logic [15:0] seg,
                                        input logic last);
    int pl;
    int ps;
    int ws;
    longint mx;
    longint my;
    result_t r;
    pl = point_floor();
    ps = Taps - 1 + pc;
    ws = Taps - 1 + wc;
    mx = weighted_mean(win_x, pc, pl);
    my = weighted_mean(win_y, pc, pl);
    win_x[ps] = mx;
    win_y[ps] = my;
    win_w[ws] = weighted_mean(win_w, wc, width_floor());
    r.kind = KindCorrected;
    r.segment_index = seg;
    r.from_x = coord_t'(win_x[ps - 1]);
    r.from_y = coord_t'(win_y[ps - 1]);
    r.to_x = coord_t'(win_x[ps]);
    r.to_y = coord_t'(win_y[ps]);
    r.width = width_t'(win_w[ws]);
    r.last = last;
    return r;
  endfunction

  function automatic int predict_segments(input pen_event_t ev, output result_t res [2]);
    longint dx;
    longint dy;
    longint px;
    longint py;
    longint w;
    logic [15:0] seg;
    int pl;
    res[0] = '0;
    res[1] = '0;
    if (ev.cmd == CmdPress) begin
      for (int i = 0; i < Taps; i++) begin
        win_x[i] = 0;
        win_y[i] = 0;
        win_w[i] = 0;
      end
      win_x[Taps - 1] = longint'(ev.pos_x);
      win_y[Taps - 1] = longint'(ev.pos_y);
      point_total = 1;
      segment_total = '0;
      stroke_open = 1'b1;
      return 0;
    end
    if (!stroke_open) return 0;
    if (ev.cmd == CmdMove) begin
      px = win_x[Taps - 1];
      py = win_y[Taps - 1];
      dx = longint'(ev.pos_x) - px;
      dy = longint'(ev.pos_y) - py;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx + dy < MinStep) return 0;
      w = (longint'(ev.pressure) * thickness_max * 3 + 8) / 16 + (thickness_max / 4) * 256;
      if (w > WidthMax) w = WidthMax;
      for (int i = 0; i < Taps - 1; i++) begin
        win_x[i] = win_x[i + 1];
        win_y[i] = win_y[i + 1];
        win_w[i] = win_w[i + 1];
      end
      win_x[Taps - 1] = longint'(ev.pos_x);
      win_y[Taps - 1] = longint'(ev.pos_y);
      win_w[Taps - 1] = w;
      if (point_total < 6) point_total++;
      seg = segment_total;
      segment_total = segment_total + 16'd1;
      res[0].kind = KindRaw;
      res[0].segment_index = seg;
      res[0].from_x = coord_t'(px);
      res[0].from_y = coord_t'(py);
      res[0].to_x = ev.pos_x;
      res[0].to_y = ev.pos_y;
      res[0].width = width_t'(w);
      res[0].last = 1'b1;
      if (point_total < 3) return 1;
      if (point_total == 3) begin
        // The first point is smoothed without a corrected segment.
        pl = point_floor();
        px = weighted_mean(win_x, -2, pl);
        py = weighted_mean(win_y, -2, pl);
        win_x[Taps - 3] = px;
        win_y[Taps - 3] = py;
        return 1;
      end
      res[0].last = 1'b0;
      res[1] = smooth_at(-2, -2, segment_total - 16'd3, 1'b1);
      return 2;
    end
    if (ev.cmd == CmdRelease) begin
      stroke_open = 1'b0;
      if (point_total <= 3) return 0;
      res[0] = smooth_at(-1, -1, segment_total - 16'd2, 1'b0);
      res[1] = smooth_at(0, 0, segment_total - 16'd1, 1'b1);
      return 2;
    end
    return 0;
  endfunction

  function automatic int draw_gap(input bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(1, 3);
      default: return $urandom_range(0, MaxGap);
    endcase
  endfunction

  function automatic coord_t clamp_coord(input longint v);
    if (v < longint'(CoordMin)) return CoordMin;
    if (v > longint'(CoordMax)) return CoordMax;
    return coord_t'(v);
  endfunction

  // Starts and ends at a falling edge. The expectation is formed at the accepting edge.
  task automatic send_event(input pen_event_t ev, input logic fixed, input result_t typed);
    int gap;
    int n;
    result_t res [2];
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= ev.cmd;
    in_if.pos_x <= ev.pos_x;
    in_if.pos_y <= ev.pos_y;
    in_if.pressure <= ev.pressure;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n = predict_segments(ev, res);
    if (fixed) begin
      expected_segments.push_back(typed);
    end else begin
      for (int i = 0; i < n; i++) expected_segments.push_back(res[i]);
    end
    events_taken++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_segments.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_thickness(input logic [ThickW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thickness_max = value;
  endtask

  // Mostly well-formed strokes with random geometry, plus noise and abandoned strokes.
  task automatic run_random(input int target);
    pen_event_t ev;
    result_t none;
    int stop_at;
    int moves;
    longint cx;
    longint cy;
    none = '0;
    stop_at = events_taken + target;
    while (events_taken < stop_at) begin
      if ($urandom_range(0, 19) == 0) in_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        ev.cmd = CmdW'($urandom_range(0, 3));
        ev.pos_x = coord_t'($urandom);
        ev.pos_y = coord_t'($urandom);
        ev.pressure = PressW'($urandom);
        send_event(ev, 1'b0, none);
      end else begin
        case ($urandom_range(0, 7))
          0: begin
            cx = longint'(CoordMin) + $urandom_range(0, 4000);
            cy = longint'(CoordMax) - $urandom_range(0, 4000);
          end
          1: begin
            cx = longint'(CoordMax) - $urandom_range(0, 4000);
            cy = longint'(CoordMin) + $urandom_range(0, 4000);
          end
          default: begin
            cx = longint'(coord_t'($urandom));
            cy = longint'(coord_t'($urandom));
          end
        endcase
        ev.cmd = CmdPress;
        ev.pos_x = coord_t'(cx);
        ev.pos_y = coord_t'(cy);
        ev.pressure = PressW'($urandom);
        send_event(ev, 1'b0, none);
        moves = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 25) : $urandom_range(0, 8);
        repeat (moves) begin
          case ($urandom_range(0, 11))
            0, 1: begin
              cx = clamp_coord(cx + int'($urandom_range(0, 254)) - 127);
              cy = clamp_coord(cy + int'($urandom_range(0, 254)) - 127);
            end
            2: begin
              cx = longint'(coord_t'($urandom));
              cy = longint'(coord_t'($urandom));
            end
            default: begin
              cx = clamp_coord(cx + int'($urandom_range(0, 6000)) - 3000);
              cy = clamp_coord(cy + int'($urandom_range(0, 6000)) - 3000);
            end
          endcase
          ev.cmd = ($urandom_range(0, 24) == 0) ? CmdUnused : CmdMove;
          ev.pos_x = coord_t'(cx);
          ev.pos_y = coord_t'(cy);
          ev.pressure = ($urandom_range(0, 9) == 0) ? PressW'($urandom_range(1025, 2047))
                                                    : PressW'($urandom_range(0, 1024));
          send_event(ev, 1'b0, none);
        end
        if ($urandom_range(0, 9) != 0) begin
          ev.cmd = CmdRelease;
          ev.pos_x = coord_t'($urandom);
          ev.pos_y = coord_t'($urandom);
          ev.pressure = PressW'($urandom);
          send_event(ev, 1'b0, none);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_segment.kind = out_if.kind;
      got_segment.segment_index = out_if.segment_index;
      got_segment.from_x = out_if.from_x;
      got_segment.from_y = out_if.from_y;
      got_segment.to_x = out_if.to_x;
      got_segment.to_y = out_if.to_y;
      got_segment.width = out_if.width;
      got_segment.last = out_if.last;
      if (expected_segments.size() == 0) begin
        $display("%0t: unexpected segment, expected none, actual %h", $time, got_segment);
        fail_count++;
      end else begin
        want_segment = expected_segments.pop_front();
        check_field("kind", 32'(want_segment.kind), 32'(got_segment.kind));
        check_field("segment_index", 32'(want_segment.segment_index),
                    32'(got_segment.segment_index));
        check_field("from_x", 32'(want_segment.from_x), 32'(got_segment.from_x));
        check_field("from_y", 32'(want_segment.from_y), 32'(got_segment.from_y));
        check_field("to_x", 32'(want_segment.to_x), 32'(got_segment.to_x));
        check_field("to_y", 32'(want_segment.to_y), 32'(got_segment.to_y));
        check_field("width", 32'(want_segment.width), 32'(got_segment.width));
        check_field("last", 32'(want_segment.last), 32'(got_segment.last));
      end
    end
  end

  // The receiver draws a random stall, possibly none, before each transfer.
  initial begin
    int gap;
    out_if.ready = 1'b0;
    out_calm = 1'b0;
    out_transfers = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_if.valid && out_if.ready)) @(posedge clk_i);
      @(negedge clk_i);
      out_transfers++;
      if (out_transfers % 32 == 0) out_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    logic [ThickW-1:0] phase_thick [PhaseCount];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.cmd = CmdPress;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pressure = '0;
    fail_count = 0;
    events_taken = 0;
    in_calm = 1'b0;
    for (int i = 0; i < Taps; i++) begin
      win_x[i] = 0;
      win_y[i] = 0;
      win_w[i] = 0;
    end
    point_total = 0;
    segment_total = '0;
    stroke_open = 1'b0;
    thickness_max = ThickReset;
    phase_thick = '{8'd255, 8'd1, 8'd3, 8'd0, 8'd4, 8'd128};
    phase_thick[3] = ThickW'($urandom_range(2, 254));
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_event(directed_rows[i].ev, directed_rows[i].fixed, directed_rows[i].res);
    end
    for (int p = 0; p < PhaseCount; p++) begin
      wait_idle();
      write_thickness(phase_thick[p]);
      run_random(PhaseItems);
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("[pen_stroke_smoother] OK");
    end else begin
      $display("[pen_stroke_smoother] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pss_pkg.sv
rtl/pss_if.sv
rtl/pss_wmean.sv
rtl/pss_out_reg.sv
rtl/pen_stroke_smoother.sv
dv/tb.sv
